// File: hdl/qpr_pkg.sv
`timescale 1ns / 1ps

package qpr_pkg;

  localparam int unsigned MapEntries = 4096;
  localparam int unsigned AddrW      = $clog2(MapEntries);
  localparam int unsigned MbShift    = 4;

  localparam int unsigned FrameW = 13;
  localparam int unsigned MapDimW = 7;
  localparam int unsigned GridW  = FrameW - MbShift + 1;
  localparam int unsigned MbW    = 8;
  localparam int unsigned ProdW  = MbW + MapDimW;
  localparam int unsigned IdxW   = 2 * MapDimW;
  localparam int unsigned QpW    = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [QpW-1:0]   DefaultQp = 6'd23;
  localparam logic [ByteW-1:0] MaxQp     = 8'd51;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMapWidth    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMapHeight   = 2'd3;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic capture;
    logic write;
    logic div_start;
    logic div_sel_y;
    logic take_x;
    logic take_y;
    logic calc_addr;
    logic read;
    logic finish;
  } qpr_cmd_t;

  typedef struct packed {
    logic lookup;
    logic div_done;
  } qpr_sts_t;

endpackage

// File: hdl/qpr_div.sv
`timescale 1ns / 1ps

module qpr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qpr_pkg::ProdW-1:0]   dividend_i,
  input  logic [qpr_pkg::GridW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [qpr_pkg::ProdW-1:0]   quotient_o
);
  import qpr_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] quo_q, quo_d;
  logic [GridW-1:0] rem_q, rem_d;
  logic [GridW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [GridW:0]   shifted;
  logic [GridW:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[ProdW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[GridW-1:0] : shifted[GridW-1:0];
      quo_d = {quo_q[ProdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/qpr_datapath.sv
`timescale 1ns / 1ps

module qpr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qpr_pkg::qpr_cmd_t             cmd_i,
  output qpr_pkg::qpr_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [qpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qpr_pkg::FrameW-1:0]    cfg_wdata_i,
  input  logic [qpr_pkg::AddrW-1:0]     entry_index_i,
  input  logic [qpr_pkg::ByteW-1:0]     entry_value_i,
  input  logic [qpr_pkg::MbW-1:0]       mb_col_i,
  input  logic [qpr_pkg::MbW-1:0]       mb_row_i,
  output logic [qpr_pkg::QpW-1:0]       mb_qp_o,
  output logic                          in_grid_o,
  output logic                          result_valid_o
);
  import qpr_pkg::*;

  logic [FrameW-1:0]  frame_width_q, frame_height_q;
  logic [MapDimW-1:0] map_width_q, map_height_q;

  logic [GridW-1:0]   grid_w, grid_h;
  logic               on_grid, lookup;
  logic [ProdW-1:0]   prod_x, prod_y;

  logic [ProdW-1:0]   prod_x_q, prod_y_q;
  logic [GridW-1:0]   grid_w_q, grid_h_q;
  logic               on_grid_q, lookup_q;
  logic [MapDimW-1:0] qx_q, qy_q;
  logic [AddrW-1:0]   addr_q;
  logic               idx_ok_q;
  logic [ByteW-1:0]   rd_q;
  logic [ByteW-1:0]   map_mem [MapEntries];

  logic [QpW-1:0]     mb_qp_q;
  logic               in_grid_q;
  logic               valid_q;

  logic               div_busy;
  logic [ProdW-1:0]   div_quo;
  logic [ProdW-1:0]   div_dividend;
  logic [GridW-1:0]   div_divisor;
  logic [MapDimW-1:0] cap_dim;
  logic [MapDimW-1:0] q_capped;
  logic [IdxW-1:0]    idx;
  logic [QpW-1:0]     clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd1920;
      frame_height_q <= 13'd1080;
      map_width_q    <= '0;
      map_height_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth:  frame_width_q  <= cfg_wdata_i;
        RegFrameHeight: frame_height_q <= cfg_wdata_i;
        RegMapWidth:    map_width_q    <= cfg_wdata_i[MapDimW-1:0];
        RegMapHeight:   map_height_q   <= cfg_wdata_i[MapDimW-1:0];
        default: ;
      endcase
    end
  end

  assign grid_w = GridW'((({1'b0, frame_width_q} + (FrameW+1)'(15)) >> MbShift));
  assign grid_h = GridW'((({1'b0, frame_height_q} + (FrameW+1)'(15)) >> MbShift));
  assign on_grid = (GridW'(mb_col_i) < grid_w) && (GridW'(mb_row_i) < grid_h);
  assign lookup = on_grid && (map_width_q != '0) && (map_height_q != '0);
  assign prod_x = ProdW'(mb_col_i) * ProdW'(map_width_q);
  assign prod_y = ProdW'(mb_row_i) * ProdW'(map_height_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prod_x_q  <= prod_x;
      prod_y_q  <= prod_y;
      grid_w_q  <= grid_w;
      grid_h_q  <= grid_h;
      on_grid_q <= on_grid;
      lookup_q  <= lookup;
    end
  end

  assign div_dividend = cmd_i.div_sel_y ? prod_y_q : prod_x_q;
  assign div_divisor  = cmd_i.div_sel_y ? grid_h_q : grid_w_q;

  qpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign cap_dim  = cmd_i.take_y ? map_height_q : map_width_q;
  assign q_capped = (div_quo < ProdW'(cap_dim)) ? div_quo[MapDimW-1:0]
                                                : cap_dim - MapDimW'(1);
  assign idx      = IdxW'(qy_q) * IdxW'(map_width_q) + IdxW'(qx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_x) begin
      qx_q <= q_capped;
    end
    if (cmd_i.take_y) begin
      qy_q <= q_capped;
    end
    if (cmd_i.calc_addr) begin
      addr_q   <= idx[AddrW-1:0];
      idx_ok_q <= (idx[IdxW-1:AddrW] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      map_mem[entry_index_i] <= entry_value_i;
    end
    if (cmd_i.read) begin
      rd_q <= map_mem[addr_q];
    end
  end

  assign clamped = (rd_q > MaxQp) ? MaxQp[QpW-1:0] : rd_q[QpW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mb_qp_q   <= (lookup_q && idx_ok_q) ? clamped : DefaultQp;
      in_grid_q <= on_grid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign sts_o.lookup   = lookup;
  assign sts_o.div_done = !div_busy;

  assign mb_qp_o        = mb_qp_q;
  assign in_grid_o      = in_grid_q;
  assign result_valid_o = valid_q;

endmodule

// File: hdl/qpr_ctrl.sv
`timescale 1ns / 1ps

module qpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              func_i,
  input  qpr_pkg::qpr_sts_t sts_i,
  output qpr_pkg::qpr_cmd_t cmd_o,
  output logic              busy_o
);
  import qpr_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StXStart = 3'd1;
  localparam logic [2:0] StXWait  = 3'd2;
  localparam logic [2:0] StYStart = 3'd3;
  localparam logic [2:0] StYWait  = 3'd4;
  localparam logic [2:0] StAddr   = 3'd5;
  localparam logic [2:0] StRead   = 3'd6;
  localparam logic [2:0] StDone   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (func_i == FuncQuery) begin
            cmd_o.capture = 1'b1;
            state_d = sts_i.lookup ? StXStart : StDone;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      StXStart: begin
        cmd_o.div_start = 1'b1;
        state_d = StXWait;
      end
      StXWait: begin
        if (sts_i.div_done) begin
          cmd_o.take_x = 1'b1;
          state_d = StYStart;
        end
      end
      StYStart: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d = StYWait;
      end
      StYWait: begin
        if (sts_i.div_done) begin
          cmd_o.take_y = 1'b1;
          state_d = StAddr;
        end
      end
      StAddr: begin
        cmd_o.calc_addr = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: hdl/qp_map_to_macroblock_resampler_top.sv
// Channel        Signals                                        Transaction
// command        start, busy, func_i, entry_index_i,            start && !busy
//                entry_value_i, mb_col_i, mb_row_i
// result         result_valid_o, mb_qp_o, in_grid_o             result_valid_o
// configuration  cfg_we_i, cfg_idx_i, cfg_wdata_i               cfg_we_i
//
// A map write gives no result.
// A query outside the grid or without a map goes straight to the done state, and its result is registered from there.
// A map lookup runs two 15-step divisions on one shared serial divider and then one
// memory read, and its result is registered after that read.
// Reset leaves the map memory unwritten; no clearing pass is run.
// The receiver cannot stall; each result is shown for one cycle only.
`timescale 1ns / 1ps

module qp_map_to_macroblock_resampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [qpr_pkg::AddrW-1:0]     entry_index_i,
  input  logic [qpr_pkg::ByteW-1:0]     entry_value_i,
  input  logic [qpr_pkg::MbW-1:0]       mb_col_i,
  input  logic [qpr_pkg::MbW-1:0]       mb_row_i,
  input  logic                          cfg_we_i,
  input  logic [qpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qpr_pkg::FrameW-1:0]    cfg_wdata_i,
  output logic [qpr_pkg::QpW-1:0]       mb_qp_o,
  output logic                          in_grid_o,
  output logic                          result_valid_o
);
  import qpr_pkg::*;

  qpr_cmd_t cmd;
  qpr_sts_t sts;

  qpr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  qpr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .mb_col_i       (mb_col_i),
    .mb_row_i       (mb_row_i),
    .mb_qp_o        (mb_qp_o),
    .in_grid_o      (in_grid_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// File: hdl/qpr_checker.sv
`timescale 1ns / 1ps

module qpr_assert_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_i,
  input logic                          func_i,
  input logic [qpr_pkg::QpW-1:0]       mb_qp_i,
  input logic                          in_grid_i,
  input logic                          result_valid_i
);
  import qpr_pkg::*;

  a_single_cycle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i)
    else $error("result strobe held for more than one cycle");

  a_qp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> (mb_qp_i <= MaxQp[QpW-1:0]))
    else $error("quantizer above the maximum");

  a_outside_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && !in_grid_i) |-> (mb_qp_i == DefaultQp))
    else $error("query outside the grid did not give the default quantizer");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && (func_i == FuncQuery)) |=> busy_i)
    else $error("query transaction did not make the block busy");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && (func_i == FuncWrite)) |=> !result_valid_i)
    else $error("map write produced a result");

endmodule

bind qp_map_to_macroblock_resampler_top qpr_assert_checker u_qpr_assert_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .func_i         (func_i),
  .mb_qp_i        (mb_qp_o),
  .in_grid_i      (in_grid_o),
  .result_valid_i (result_valid_o)
);

// File: bench/qpr_checker.sv
`timescale 1ns / 1ps

module qpr_checker
  import qpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                func_i,
  input  logic [AddrW-1:0]    entry_index_i,
  input  logic [ByteW-1:0]    entry_value_i,
  input  logic [MbW-1:0]      mb_col_i,
  input  logic [MbW-1:0]      mb_row_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [FrameW-1:0]   cfg_wdata_i,
  input  logic [QpW-1:0]      mb_qp_i,
  input  logic                in_grid_i,
  input  logic                result_valid_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [QpW-1:0] qp;
    logic           in_grid;
  } mb_result_t;

  logic [FrameW-1:0]  frame_w;
  logic [FrameW-1:0]  frame_h;
  logic [MapDimW-1:0] map_w;
  logic [MapDimW-1:0] map_h;
  logic [ByteW-1:0]   map_mem [MapEntries];
  mb_result_t         expected_q [$];
  int unsigned        fails;

  function automatic mb_result_t resample_qp(input logic [MbW-1:0] col,
                                             input logic [MbW-1:0] row);
    int unsigned grid_w;
    int unsigned grid_h;
    int unsigned map_x;
    int unsigned map_y;
    int unsigned addr;
    mb_result_t  res;
    grid_w = (32'(frame_w) + 32'd15) >> MbShift;
    grid_h = (32'(frame_h) + 32'd15) >> MbShift;
    res.in_grid = (32'(col) < grid_w) && (32'(row) < grid_h);
    res.qp = DefaultQp;
    if (res.in_grid && map_w != '0 && map_h != '0) begin
      map_x = (32'(col) * 32'(map_w)) / grid_w;
      if (map_x > 32'(map_w) - 1) map_x = 32'(map_w) - 1;
      map_y = (32'(row) * 32'(map_h)) / grid_h;
      if (map_y > 32'(map_h) - 1) map_y = 32'(map_h) - 1;
      addr = map_y * 32'(map_w) + map_x;
      if (addr < MapEntries) begin
        if (map_mem[addr] > MaxQp) res.qp = QpW'(MaxQp);
        else res.qp = map_mem[addr][QpW-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mb_result_t oldest;
    if (!rst_ni) begin
      frame_w <= 13'd1920;
      frame_h <= 13'd1080;
      map_w <= '0;
      map_h <= '0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: mb_qp %0d in_grid %0d", mb_qp_i, in_grid_i);
          fails++;
        end else begin
          oldest = expected_q.pop_front();
          if (mb_qp_i !== oldest.qp) begin
            $error("mb_qp mismatch: expected %0d, actual %0d", oldest.qp, mb_qp_i);
            fails++;
          end
          if (in_grid_i !== oldest.in_grid) begin
            $error("in_grid mismatch: expected %0d, actual %0d", oldest.in_grid, in_grid_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (func_i == FuncWrite) map_mem[entry_index_i] <= entry_value_i;
        else expected_q.push_back(resample_qp(mb_col_i, mb_row_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFrameWidth:  frame_w <= cfg_wdata_i;
          RegFrameHeight: frame_h <= cfg_wdata_i;
          RegMapWidth:    map_w <= cfg_wdata_i[MapDimW-1:0];
          RegMapHeight:   map_h <= cfg_wdata_i[MapDimW-1:0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: bench/tb_qp_map_to_macroblock_resampler_top.sv
`timescale 1ns / 1ps

module tb_qp_map_to_macroblock_resampler_top;
  import qpr_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned Phases      = 12;
  localparam int unsigned PhaseItems  = 27;
  localparam int unsigned MapFill     = 256;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               func_i = FuncWrite;
  logic [AddrW-1:0]   entry_index_i = '0;
  logic [ByteW-1:0]   entry_value_i = '0;
  logic [MbW-1:0]     mb_col_i = '0;
  logic [MbW-1:0]     mb_row_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegFrameWidth;
  logic [FrameW-1:0]  cfg_wdata_i = '0;
  logic [QpW-1:0]     mb_qp_o;
  logic               in_grid_o;
  logic               result_valid_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned grid_cols = 0;
  int unsigned grid_rows = 0;
  bit          idle_en = 1'b1;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  qp_map_to_macroblock_resampler_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .mb_col_i       (mb_col_i),
    .mb_row_i       (mb_row_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mb_qp_o        (mb_qp_o),
    .in_grid_o      (in_grid_o),
    .result_valid_o (result_valid_o)
  );

  qpr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .mb_col_i       (mb_col_i),
    .mb_row_i       (mb_row_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mb_qp_i        (mb_qp_o),
    .in_grid_i      (in_grid_o),
    .result_valid_i (result_valid_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_qp_map_to_macroblock_resampler_top NOT OK");
      $finish;
    end
  end

  // Start stays high from one transaction to the next unless an idle burst follows.
  task automatic issue(input logic f, input logic [AddrW-1:0] idx, input logic [ByteW-1:0] val,
                       input logic [MbW-1:0] col, input logic [MbW-1:0] row);
    start <= 1'b1;
    func_i <= f;
    entry_index_i <= idx;
    entry_value_i <= val;
    mb_col_i <= col;
    mb_row_i <= row;
    do @(posedge clk_i); while (busy);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic write_entry(input int unsigned idx, input int unsigned val);
    issue(FuncWrite, AddrW'(idx), ByteW'(val), MbW'($urandom), MbW'($urandom));
  endtask

  task automatic query_mb(input int unsigned col, input int unsigned row);
    issue(FuncQuery, AddrW'($urandom), ByteW'($urandom), MbW'(col), MbW'(row));
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= FrameW'(val);
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned fw, input int unsigned fh,
                            input int unsigned mw, input int unsigned mh);
    write_reg(RegFrameWidth, fw);
    write_reg(RegFrameHeight, fh);
    write_reg(RegMapWidth, mw);
    write_reg(RegMapHeight, mh);
    cfg_we_i <= 1'b0;
    grid_cols = (fw + 15) / 16;
    grid_rows = (fh + 15) / 16;
  endtask

  function automatic int unsigned pick_frame_dim();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 8191);
    return 2 * $urandom_range(1, 2048);
  endfunction

  function automatic int unsigned pick_map_dim(input int unsigned limit);
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, limit);
  endfunction

  // The map size stays within the filled entries so every lookup reads a written location.
  task automatic random_config();
    int unsigned mw;
    int unsigned mh;
    mw = pick_map_dim(127);
    mh = pick_map_dim((mw == 0 || MapFill / mw > 127) ? 127 : MapFill / mw);
    set_config(pick_frame_dim(), pick_frame_dim(), mw, mh);
  endtask

  task automatic random_item();
    int unsigned col;
    int unsigned row;
    if ($urandom_range(0, 3) == 0) begin
      write_entry($urandom_range(0, MapEntries - 1), $urandom_range(0, 255));
    end else begin
      if ($urandom_range(0, 9) != 0 && grid_cols > 0 && grid_rows > 0) begin
        col = $urandom_range(0, ((grid_cols > 256) ? 256 : grid_cols) - 1);
        row = $urandom_range(0, ((grid_rows > 256) ? 256 : grid_rows) - 1);
      end else begin
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
      end
      query_mb(col, row);
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration has no map, so these queries never touch the memory.
    query_mb(0, 0);
    query_mb(119, 67);
    query_mb(120, 0);
    query_mb(0, 68);
    query_mb(255, 255);

    // Fill the low entries; lookups stay in them, hit a written entry or index beyond memory.
    for (int unsigned i = 0; i < MapFill; i++) write_entry(i, $urandom_range(0, 255));
    settle();

    set_config(1920, 1080, 64, 64);
    write_entry(0, 255);
    write_entry(MapEntries - 1, 0);
    write_entry(1, 51);
    write_entry(2, 52);
    query_mb(0, 0);
    query_mb(119, 67);
    query_mb(2, 0);
    query_mb(4, 0);
    settle();
    set_config(1920, 1080, 127, 127);
    query_mb(119, 67);
    query_mb(0, 0);
    settle();
    set_config(0, 0, 64, 64);
    query_mb(0, 0);
    settle();
    set_config(8191, 8191, 1, 1);
    query_mb(255, 255);
    settle();
    set_config(2, 2, 64, 64);
    query_mb(0, 0);
    query_mb(1, 0);
    query_mb(0, 1);
    settle();
    set_config(1920, 1080, 0, 5);
    query_mb(3, 3);
    settle();
    set_config(1920, 1080, 5, 0);
    query_mb(3, 3);
    settle();

    for (phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: set_config(8191, 8191, 127, 2);
        1: set_config(2, 2, 1, 1);
        2: set_config(4096, 4096, 16, 16);
        3: set_config(1, 4096, 64, 1);
        default: random_config();
      endcase
      idle_en = (phase < Phases - 2);
      repeat (PhaseItems) random_item();
      settle();
    end

    if (fail_count == 0) begin
      $display("tb_qp_map_to_macroblock_resampler_top OK");
    end else begin
      $display("tb_qp_map_to_macroblock_resampler_top NOT OK");
    end
    $finish;
  end

endmodule
